/* sv/sqcf_pkg.sv */
// sqcf_pkg: shared types for the square-root continued fraction period block
// no dependencies; used by sqrt_continued_fraction_period
`default_nettype none

package sqcf_pkg;

  // sequencer states, one-hot
  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_ROOT = 10'b00_0000_0010,
    S_MUL1 = 10'b00_0000_0100,
    S_SUB1 = 10'b00_0000_1000,
    S_MUL2 = 10'b00_0001_0000,
    S_LD1  = 10'b00_0010_0000,
    S_DIV1 = 10'b00_0100_0000,
    S_LD2  = 10'b00_1000_0000,
    S_DIV2 = 10'b01_0000_0000,
    S_DONE = 10'b10_0000_0000
  } state_t;

endpackage

`default_nettype wire

/* sv/sqrt_continued_fraction_period.sv */
// sqrt_continued_fraction_period: period of the continued fraction of sqrt(n)
// depends on sqcf_pkg (state type)
//
// Usage:
//   Input channel (in_valid / in_ready / n) takes one word n. Output channel
//   (out_valid / out_ready / period, period_odd, is_square, saturated) gives
//   one result word per input word.
//   in_ready is high only while the block is idle; one word is worked on at
//   a time.
// Sequence:
//   the word is taken, then the integer square root is formed, two bits per
//   cycle; then each term of the expansion takes two multiplier passes and
//   two bit-serial divisions on the one shared restoring divider.
//   A perfect square finishes right after the root; otherwise the block
//   finishes once the period has been found or the term counter saturates.
// Stall:
//   the result is held in the output register while out_ready is low; the
//   block takes the next word once the result has been taken.
// Reset:
//   synchronous rst returns the sequencer to idle and drops out_valid.
`default_nettype none

module sqrt_continued_fraction_period #(
  parameter int N_WIDTH      = 32,
  parameter int PERIOD_WIDTH = 24
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [N_WIDTH-1:0]      n,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [PERIOD_WIDTH-1:0]      period,
  output logic                         period_odd,
  output logic                         is_square,
  output logic                         saturated
);

  localparam int H  = (N_WIDTH + 1) / 2;   // bits of floor(sqrt(n))
  localparam int PW = 2 * H + 2;           // product width
  localparam int CW = $clog2(N_WIDTH);     // step counter width
  localparam logic [CW-1:0] ROOT_LAST = CW'(H - 1);
  localparam logic [CW-1:0] DIV_LAST  = CW'(N_WIDTH - 1);
  localparam logic [PERIOD_WIDTH-1:0] PERIOD_MAX = {PERIOD_WIDTH{1'b1}};

  sqcf_pkg::state_t state;

  logic [N_WIDTH-1:0]      nreg;
  logic [2*H-1:0]          sq_src;
  logic [H:0]              sq_rem;
  logic [H-1:0]            sq_root;
  logic [H-1:0]            a0;
  logic [H-1:0]            m;
  logic [H:0]              d;
  logic [H:0]              a;
  logic [PW-1:0]           prod;
  logic [N_WIDTH-1:0]      dq;
  logic [H:0]              drem;
  logic [CW-1:0]           step;
  logic [PERIOD_WIDTH-1:0] count;

  // integer square root, two bits per cycle
  logic [H+2:0] sq_sh, sq_trial, sq_diff;
  logic         sq_ge;
  logic [H:0]   sq_rem_next;
  logic [H-1:0] sq_root_next;

  assign sq_sh        = {sq_rem, sq_src[2*H-1 -: 2]};
  assign sq_trial     = {1'b0, sq_root, 2'b01};
  assign sq_ge        = (sq_sh >= sq_trial);
  assign sq_diff      = sq_sh - sq_trial;
  assign sq_rem_next  = sq_ge ? sq_diff[H:0] : sq_sh[H:0];
  assign sq_root_next = {sq_root[H-2:0], sq_ge};

  // shared restoring divider step, divisor is d
  logic [H+1:0]         dv_sh, dv_diff;
  logic                 dv_ge;
  logic [H:0]           drem_next;
  logic [N_WIDTH-1:0]   dq_next;

  assign dv_sh     = {drem, dq[N_WIDTH-1]};
  assign dv_ge     = (dv_sh >= {1'b0, d});
  assign dv_diff   = dv_sh - {1'b0, d};
  assign drem_next = dv_ge ? dv_diff[H:0] : dv_sh[H:0];
  assign dq_next   = {dq[N_WIDTH-2:0], dv_ge};

  // shared multiplier: d*a in the first pass, m*m in the second
  logic [H:0]    mul_x, mul_y;
  logic [PW-1:0] mul_out;

  assign mul_x   = (state == sqcf_pkg::S_MUL1) ? d : {1'b0, m};
  assign mul_y   = (state == sqcf_pkg::S_MUL1) ? a : {1'b0, m};
  assign mul_out = PW'(mul_x) * PW'(mul_y);

  // end-of-term values
  logic [PERIOD_WIDTH-1:0] count_next;
  logic [H:0]              a_new;
  logic                    closed;

  assign count_next = count + 1'b1;
  assign a_new      = dq_next[H:0];
  assign closed     = (a_new == {a0, 1'b0});

  assign in_ready = (state == sqcf_pkg::S_IDLE);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sqcf_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        sqcf_pkg::S_IDLE: begin
          if (in_valid) state <= sqcf_pkg::S_ROOT;
        end
        sqcf_pkg::S_ROOT: begin
          if (step == ROOT_LAST) begin
            if (sq_rem_next == '0) begin
              state     <= sqcf_pkg::S_DONE;
              out_valid <= 1'b1;
            end else begin
              state <= sqcf_pkg::S_MUL1;
            end
          end
        end
        sqcf_pkg::S_MUL1: state <= sqcf_pkg::S_SUB1;
        sqcf_pkg::S_SUB1: state <= sqcf_pkg::S_MUL2;
        sqcf_pkg::S_MUL2: state <= sqcf_pkg::S_LD1;
        sqcf_pkg::S_LD1:  state <= sqcf_pkg::S_DIV1;
        sqcf_pkg::S_DIV1: begin
          if (step == DIV_LAST) state <= sqcf_pkg::S_LD2;
        end
        sqcf_pkg::S_LD2:  state <= sqcf_pkg::S_DIV2;
        sqcf_pkg::S_DIV2: begin
          if (step == DIV_LAST) begin
            if (closed || count_next == PERIOD_MAX) begin
              state     <= sqcf_pkg::S_DONE;
              out_valid <= 1'b1;
            end else begin
              state <= sqcf_pkg::S_MUL1;
            end
          end
        end
        sqcf_pkg::S_DONE: begin
          if (out_ready) begin
            state     <= sqcf_pkg::S_IDLE;
            out_valid <= 1'b0;
          end
        end
        default: begin
          state     <= sqcf_pkg::S_IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      sqcf_pkg::S_IDLE: begin
        nreg    <= n;
        sq_src  <= (2*H)'(n);
        sq_rem  <= '0;
        sq_root <= '0;
        step    <= '0;
      end
      sqcf_pkg::S_ROOT: begin
        sq_src  <= {sq_src[2*H-3:0], 2'b00};
        sq_rem  <= sq_rem_next;
        sq_root <= sq_root_next;
        step    <= step + 1'b1;
        if (step == ROOT_LAST) begin
          a0    <= sq_root_next;
          m     <= '0;
          d     <= (H+1)'(1);
          a     <= {1'b0, sq_root_next};
          count <= '0;
          if (sq_rem_next == '0) begin
            period     <= '0;
            period_odd <= 1'b0;
            is_square  <= 1'b1;
            saturated  <= 1'b0;
          end
        end
      end
      sqcf_pkg::S_MUL1: prod <= mul_out;
      // m' = d*a - m
      sqcf_pkg::S_SUB1: m <= prod[H-1:0] - m;
      sqcf_pkg::S_MUL2: prod <= mul_out;
      // dividend n - m'*m'
      sqcf_pkg::S_LD1: begin
        dq   <= nreg - prod[N_WIDTH-1:0];
        drem <= '0;
        step <= '0;
      end
      sqcf_pkg::S_DIV1: begin
        dq   <= dq_next;
        drem <= drem_next;
        step <= step + 1'b1;
        if (step == DIV_LAST) begin
          // zero divisor guard
          d <= (dq_next == '0) ? (H+1)'(1) : dq_next[H:0];
        end
      end
      // dividend a0 + m'
      sqcf_pkg::S_LD2: begin
        dq   <= N_WIDTH'({1'b0, a0} + {1'b0, m});
        drem <= '0;
        step <= '0;
      end
      sqcf_pkg::S_DIV2: begin
        dq   <= dq_next;
        drem <= drem_next;
        step <= step + 1'b1;
        if (step == DIV_LAST) begin
          a     <= a_new;
          count <= count_next;
          if (closed || count_next == PERIOD_MAX) begin
            period     <= count_next;
            period_odd <= closed & count_next[0];
            is_square  <= 1'b0;
            saturated  <= ~closed;
          end
        end
      end
      sqcf_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/sqcf_checker.sv */
// sqcf_checker: port-level assertions for sqrt_continued_fraction_period
// no package dependency; attached to the top level by the bind below
`default_nettype none

module sqcf_checker #(
  parameter int PERIOD_WIDTH = 24
) (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [PERIOD_WIDTH-1:0] period,
  input wire logic                    period_odd,
  input wire logic                    is_square,
  input wire logic                    saturated
);

  // one word in flight: never ready for input while a result waits
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  // a result never appears in the cycle after a word is taken
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid)
    else $error("result right after accept");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(period)
      && $stable(period_odd) && $stable(is_square) && $stable(saturated)))
    else $error("stalled result changed");

  // perfect square gives an empty block
  a_square: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_square) |-> (period == '0 && !period_odd && !saturated))
    else $error("bad perfect square result");

  // saturation only at the counter maximum, parity cleared
  a_sat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |-> (period == {PERIOD_WIDTH{1'b1}} && !period_odd
      && !is_square))
    else $error("bad saturated result");

endmodule

bind sqrt_continued_fraction_period sqcf_checker #(
  .PERIOD_WIDTH(PERIOD_WIDTH)
) u_sqcf_checker (.*);

`default_nettype wire

/* bench/tb_sqrt_continued_fraction_period.sv */
// tb_sqrt_continued_fraction_period: self-checking bench for the continued fraction period block
// depends on sqrt_continued_fraction_period (and through it sqcf_pkg); predicts each result
// word in the bench and checks every output word against the oldest prediction
`timescale 1ns / 100ps

module tb_sqrt_continued_fraction_period;

  localparam int N_W      = 32;
  localparam int PERIOD_W = 24;
  localparam longint unsigned PERIOD_LIMIT = (64'd1 << PERIOD_W) - 1;
  // watchdog allowances for the root and for one term of the expansion
  localparam int ROOT_CYCLES = (N_W + 1) / 2 + 2;
  localparam int TERM_CYCLES = 2 * N_W + 5;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic                odd;
    logic                square;
    logic                sat;
  } cf_result_t;

  typedef struct {
    logic [N_W-1:0] n;
    cf_result_t     res;
  } cf_pending_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [N_W-1:0]      n;
  logic                out_valid;
  logic                out_ready;
  logic [PERIOD_W-1:0] period;
  logic                period_odd;
  logic                is_square;
  logic                saturated;

  cf_pending_t pending_q[$];
  int unsigned errors;
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned squares_seen;
  int unsigned odd_seen;
  int unsigned longest_period;
  longint unsigned cycle_count;
  longint unsigned cycle_budget;
  logic        steady;
  int unsigned hold_requests;
  int unsigned hold_served;
  int unsigned hold_left;

  sqrt_continued_fraction_period #(
    .N_WIDTH      (N_W),
    .PERIOD_WIDTH (PERIOD_W)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .n          (n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .period     (period),
    .period_odd (period_odd),
    .is_square  (is_square),
    .saturated  (saturated)
  );

  always #5 clk = ~clk;

  // period of the continued fraction of sqrt(val), with the square and overflow flags
  function automatic cf_result_t cf_period_of(input logic [N_W-1:0] val);
    longint unsigned x;
    longint unsigned root;
    longint unsigned m;
    longint unsigned d;
    longint unsigned a;
    longint unsigned terms;
    cf_result_t r;
    x = 64'(val);
    r = '0;
    // floating estimate of the root, then nudged to the exact floor
    root = 64'($rtoi($sqrt(real'(x))));
    while (root * root > x) root--;
    while ((root + 1) * (root + 1) <= x) root++;
    if (root * root == x) begin
      r.square = 1'b1;
      return r;
    end
    m = 0;
    d = 1;
    a = root;
    terms = 0;
    forever begin
      m = d * a - m;
      d = (x - m * m) / d;
      if (d == 0) d = 1;
      a = (root + m) / d;
      terms++;
      // a term of twice the root closes the repeating block
      if (a == 2 * root) break;
      if (terms >= PERIOD_LIMIT) begin
        r.sat = 1'b1;
        break;
      end
    end
    r.period = terms[PERIOD_W-1:0];
    r.odd    = r.sat ? 1'b0 : terms[0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // offer one word after an occasional random gap, wait for the handshake, then record the predicted result
  task automatic send_word(input logic [N_W-1:0] val);
    cf_pending_t p;
    int gap;
    if (!steady && $urandom_range(0, 99) < 12) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    n        <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p.n   = val;
    p.res = cf_period_of(val);
    pending_q.push_back(p);
    words_sent++;
    if (p.res.square) squares_seen++;
    if (p.res.odd) odd_seen++;
    if (32'(p.res.period) > longest_period) longest_period = 32'(p.res.period);
    cycle_budget += 4 * (ROOT_CYCLES + longint'(p.res.period) * TERM_CYCLES) + 200;
  endtask

  // receiver: random stalls, a quiet stretch, and long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_CYCLES - 1;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 12);
    end
  end

  // compare each result word with the oldest prediction
  always @(posedge clk) begin
    cf_pending_t p;
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result word with nothing expected: period %0d", period));
      end else begin
        p = pending_q.pop_front();
        words_checked++;
        if (period !== p.res.period)
          report_mismatch($sformatf("n=%0d period got %0d exp %0d", p.n, period, p.res.period));
        if (period_odd !== p.res.odd)
          report_mismatch($sformatf("n=%0d period_odd got %b exp %b", p.n, period_odd,
                                    p.res.odd));
        if (is_square !== p.res.square)
          report_mismatch($sformatf("n=%0d is_square got %b exp %b", p.n, is_square,
                                    p.res.square));
        if (saturated !== p.res.sat)
          report_mismatch($sformatf("n=%0d saturated got %b exp %b", p.n, saturated,
                                    p.res.sat));
      end
    end
  end

  // watchdog: the budget grows with the predicted work of every accepted word
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > cycle_budget) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_count,
               pending_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // zero, squares at both ends, the largest inputs, and short known periods
  task automatic test_directed();
    logic [N_W-1:0] vals[$];
    vals = {32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd7, 32'd13, 32'd94, 32'd139, 32'd661,
            32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFE_0001, 32'hFFFE_0002, 32'hFFFE_0003,
            32'hFFFF_0000, 32'd1000000, 32'd999_998_000};
    foreach (vals[i]) send_word(vals[i]);
  endtask

  // small values: periods from 0 up to around a hundred terms
  task automatic test_random_small(input int count);
    repeat (count) send_word($urandom_range(0, 4095));
  endtask

  // values just around large squares: every input bit toggles, periods stay short
  task automatic test_near_squares(input int count);
    longint unsigned k;
    longint unsigned v;
    steady = 1'b1;
    repeat (count) begin
      k = 64'($urandom_range(2, 65535));
      case ($urandom_range(0, 5))
        0: v = k * k;
        1: v = k * k + 1;
        2: v = k * k + 2;
        3: v = k * k - 1;
        4: v = k * k - 2;
        default: v = k * k + k;
      endcase
      send_word(v[N_W-1:0]);
    end
    steady = 1'b0;
  endtask

  // a few medium values with longer periods
  task automatic test_random_medium(input int count);
    repeat (count) send_word($urandom_range(4096, 65535));
  endtask

  // receiver holds off while words keep coming, so the input side stalls
  task automatic test_backpressure(input int count);
    hold_requests <= hold_requests + 1;
    cycle_budget += HOLD_CYCLES;
    repeat (count) send_word($urandom_range(2, 200));
  endtask

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    in_valid       = 1'b0;
    n              = '0;
    errors         = 0;
    words_sent     = 0;
    words_checked  = 0;
    squares_seen   = 0;
    odd_seen       = 0;
    longest_period = 0;
    cycle_count    = 0;
    cycle_budget   = 20000;
    steady         = 1'b0;
    hold_requests  = 0;
    hold_served    = 0;
    hold_left      = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_small(74);
    test_near_squares(30);
    test_backpressure(6);
    test_random_medium(12);

    // let the last words drain
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (ROOT_CYCLES + TERM_CYCLES) @(posedge clk);

    $display("covered %0d words (%0d checked): %0d squares, %0d odd periods, longest %0d",
             words_sent, words_checked, squares_seen, odd_seen, longest_period);
    $display("with random stalls on both sides and a %0d-cycle receiver hold-off",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
